### rtl/core/qrs_pkg.sv
// Shared constants and types for the quadratic root solver.
package qrs_pkg;

    localparam int COEF_W     = 32;
    localparam int IN_DATA_W  = 3 * COEF_W;
    localparam int OUT_DATA_W = 72;
    localparam int OUT_USER_W = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int LIMIT_W    = 31;

    // restoring divider: 64-bit dividend, 33-bit divisor, one quotient bit per stage
    localparam int DIV_NUM_W  = 64;
    localparam int DIV_DEN_W  = 33;
    localparam int DIV_STAGES = DIV_NUM_W;

    // square root: one root bit per stage
    localparam int SQ_ROOT_W  = 34;
    localparam int SQ_RAD_W   = 2 * SQ_ROOT_W;
    localparam int SQ_REM_W   = SQ_ROOT_W + 3;
    localparam int SQ_STEPS   = SQ_ROOT_W;

    localparam int DISC_W     = 67;
    localparam int RES_W      = 96;

    // clamp and residual stages after the root dividers
    localparam int TAIL_N     = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_EN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = 1'b1;

    typedef enum logic [OUT_USER_W-1:0] {
        KIND_NONE    = 3'd0,
        KIND_LINEAR  = 3'd1,
        KIND_ZERO    = 3'd2,
        KIND_DOUBLE  = 3'd3,
        KIND_TWO     = 3'd4,
        KIND_NO_REAL = 3'd5
    } t_kind;

endpackage

### rtl/core/qrs_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module qrs_div import qrs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [DIV_DEN_W-1:0] i_den,
    output logic [DIV_NUM_W-1:0] o_quo
);

    logic [DIV_DEN_W-1:0] r_rem [DIV_STAGES];
    logic [DIV_NUM_W-1:0] r_num [DIV_STAGES];
    logic [DIV_NUM_W-1:0] r_quo [DIV_STAGES];
    logic [DIV_DEN_W-1:0] r_den [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [DIV_DEN_W-1:0] w_rem_p;
        logic [DIV_NUM_W-1:0] w_num_p;
        logic [DIV_NUM_W-1:0] w_quo_p;
        logic [DIV_DEN_W-1:0] w_den_p;
        logic [DIV_DEN_W:0]   w_trial;
        logic [DIV_DEN_W+1:0] w_diff;

        if (k == 0) begin : g_first
            assign w_rem_p = '0;
            assign w_num_p = i_num;
            assign w_quo_p = '0;
            assign w_den_p = i_den;
        end else begin : g_next
            assign w_rem_p = r_rem[k-1];
            assign w_num_p = r_num[k-1];
            assign w_quo_p = r_quo[k-1];
            assign w_den_p = r_den[k-1];
        end

        assign w_trial = {w_rem_p, w_num_p[DIV_NUM_W-1]};
        assign w_diff  = {1'b0, w_trial} - {2'b00, w_den_p};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[k] <= {w_num_p[DIV_NUM_W-2:0], 1'b0};
                r_den[k] <= w_den_p;
                if (!w_diff[DIV_DEN_W+1]) begin
                    r_rem[k] <= w_diff[DIV_DEN_W-1:0];
                    r_quo[k] <= {w_quo_p[DIV_NUM_W-2:0], 1'b1};
                end else begin
                    r_rem[k] <= w_trial[DIV_DEN_W-1:0];
                    r_quo[k] <= {w_quo_p[DIV_NUM_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_quo = r_quo[DIV_STAGES-1];

endmodule

### rtl/core/qrs_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module qrs_sqrt import qrs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [SQ_RAD_W-1:0]  i_rad,
    output logic [SQ_ROOT_W-1:0] o_root
);

    logic [SQ_REM_W-1:0]  r_rem  [SQ_STEPS];
    logic [SQ_RAD_W-1:0]  r_rad  [SQ_STEPS];
    logic [SQ_ROOT_W-1:0] r_root [SQ_STEPS];

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
        logic [SQ_REM_W-1:0]  w_rem_p;
        logic [SQ_RAD_W-1:0]  w_rad_p;
        logic [SQ_ROOT_W-1:0] w_root_p;
        logic [SQ_REM_W-1:0]  w_sh;
        logic [SQ_REM_W-1:0]  w_trial;
        logic [SQ_REM_W:0]    w_diff;

        if (k == 0) begin : g_first
            assign w_rem_p  = '0;
            assign w_rad_p  = i_rad;
            assign w_root_p = '0;
        end else begin : g_next
            assign w_rem_p  = r_rem[k-1];
            assign w_rad_p  = r_rad[k-1];
            assign w_root_p = r_root[k-1];
        end

        // remainder stays below 2*root+1, so the two dropped bits are zero
        assign w_sh    = {w_rem_p[SQ_REM_W-3:0], w_rad_p[SQ_RAD_W-1 -: 2]};
        assign w_trial = {{(SQ_REM_W-SQ_ROOT_W-2){1'b0}}, w_root_p, 2'b01};
        assign w_diff  = {1'b0, w_sh} - {1'b0, w_trial};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k] <= {w_rad_p[SQ_RAD_W-3:0], 2'b00};
                if (!w_diff[SQ_REM_W]) begin
                    r_rem[k]  <= w_diff[SQ_REM_W-1:0];
                    r_root[k] <= {w_root_p[SQ_ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem[k]  <= w_sh;
                    r_root[k] <= {w_root_p[SQ_ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_root = r_root[SQ_STEPS-1];

endmodule

### rtl/core/quadratic_root_solver_core.sv
// Top level: real roots of a*x^2 + b*x + c in Q16.16, fully pipelined.
//
//  channel   | dir | handshake             | payload (low bit first)
//  ----------+-----+-----------------------+-------------------------------------------
//  s_axis    | in  | i_s_tvalid/o_s_tready | tdata: coef_quad, coef_lin, coef_const
//  m_axis    | out | o_m_tvalid/i_m_tready | tuser: root_kind
//            |     |                       | tdata: root_first, root_second,
//            |     |                       |        poor_first, poor_second, saturated
//  cfg       | in  | i_cfg_we              | i_cfg_index, i_cfg_data
//
// One item per cycle while the output buffer is not full. The path from accept to
// the earliest output handshake chains the long units:
// a 64-stage divider (b = 0 case), the 34-stage square root and the 64-stage
// root dividers, plus front and residual stages.
// Reset (synchronous, active low) clears all valid bits and the output buffer
// and sets check_enable = 1, residual_limit = 1.
// The whole pipeline advances together; it holds only while the two-entry
// output buffer is full, so one waiting result never blocks input.
module quadratic_root_solver_core import qrs_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // coef_quad [31:0], coef_lin [63:32], coef_const [95:64]
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // root_first [31:0], root_second [63:32], poor_first [64],
    // poor_second [65], saturated [66], zero [71:67]
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    // root_kind [2:0]
    output logic [OUT_USER_W-1:0] o_m_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [LIMIT_W-1:0]    i_cfg_data
);

    typedef struct packed {
        logic              vld;
        logic              a_neg, b_neg, c_neg;
        logic              a0, b0, c0;
        logic [COEF_W-1:0] am, bm, cm;
        logic [COEF_W-1:0] b;
    } t_s1;

    typedef struct packed {
        t_s1                 s;
        logic [2*COEF_W-1:0] bb;
        logic [2*COEF_W-1:0] ac;
    } t_s2;

    // item context carried along the long divider / root stages
    typedef struct packed {
        logic              vld;
        t_kind             kind;
        logic              sqb0;     // b = 0 with roots +-sqrt(-c/a)
        logic              a_neg, b_neg, c_neg, c_pos;
        logic [COEF_W-1:0] am, bm, cm;
        logic [COEF_W-1:0] b;
        logic [DISC_W-1:0] disc;
        logic              neg1, neg2;
    } t_side;

    typedef struct packed {
        t_side                sd;
        logic [DIV_NUM_W-1:0] num1, num2;
        logic [DIV_DEN_W-1:0] den;
    } t_s4;

    typedef struct packed {
        logic                   vld;
        t_kind                  kind;
        logic                   a_neg, b_neg, c_neg;
        logic [COEF_W-1:0]      am, bm, cm;
        logic                   sat;
        logic [1:0]             rep;
        logic [1:0][COEF_W-1:0] x;
        logic [1:0][COEF_W-1:0] xm;
        logic [1:0]             xneg;
    } t_tail;

    typedef struct packed {
        t_kind             kind;
        logic [COEF_W-1:0] r1, r2;
        logic              p1, p2, sat;
    } t_out;

    // tail stages S5 .. S11

    // ---------------- control ----------------
    logic       w_en;
    logic [1:0] r_cnt;
    logic       r_wp, r_rp;
    logic       w_push, w_pop;

    assign w_en       = (r_cnt != 2'd2);
    assign o_s_tready = w_en;

    // ---------------- configuration ----------------
    logic               r_check_en;
    logic [LIMIT_W-1:0] r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_en <= 1'b1;
            r_limit    <= LIMIT_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CHECK_EN: r_check_en <= i_cfg_data[0];
                CFG_LIMIT:    r_limit    <= i_cfg_data;
            endcase
        end
    end

    // ---------------- S1: magnitudes and flags ----------------
    t_s1 r_s1, n_s1;
    logic [COEF_W-1:0] w_a, w_b, w_c;

    assign w_a = i_s_tdata[COEF_W-1:0];
    assign w_b = i_s_tdata[2*COEF_W-1:COEF_W];
    assign w_c = i_s_tdata[3*COEF_W-1:2*COEF_W];

    always_comb begin
        n_s1       = '0;
        n_s1.vld   = i_s_tvalid;
        n_s1.a_neg = w_a[COEF_W-1];
        n_s1.b_neg = w_b[COEF_W-1];
        n_s1.c_neg = w_c[COEF_W-1];
        n_s1.a0    = (w_a == '0);
        n_s1.b0    = (w_b == '0);
        n_s1.c0    = (w_c == '0);
        n_s1.am    = w_a[COEF_W-1] ? COEF_W'(0) - w_a : w_a;
        n_s1.bm    = w_b[COEF_W-1] ? COEF_W'(0) - w_b : w_b;
        n_s1.cm    = w_c[COEF_W-1] ? COEF_W'(0) - w_c : w_c;
        n_s1.b     = w_b;
    end

    // ---------------- S2: b*b and a*c ----------------
    t_s2 r_s2;

    // ---------------- S3: discriminant and case ----------------
    t_side r_s3, n_s3;
    logic [2*COEF_W+1:0] w_p4;
    logic                w_lt, w_eq, w_acn;

    always_comb begin
        w_p4  = {r_s2.ac, 2'b00};
        w_lt  = ({2'b00, r_s2.bb} < w_p4);
        w_eq  = ({2'b00, r_s2.bb} == w_p4);
        w_acn = r_s2.s.a_neg ^ r_s2.s.c_neg;

        n_s3       = '0;
        n_s3.vld   = r_s2.s.vld;
        n_s3.a_neg = r_s2.s.a_neg;
        n_s3.b_neg = r_s2.s.b_neg;
        n_s3.c_neg = r_s2.s.c_neg;
        n_s3.c_pos = !r_s2.s.c_neg && !r_s2.s.c0;
        n_s3.am    = r_s2.s.am;
        n_s3.bm    = r_s2.s.bm;
        n_s3.cm    = r_s2.s.cm;
        n_s3.b     = r_s2.s.b;
        n_s3.kind  = KIND_TWO;

        if (r_s2.s.c0) begin
            n_s3.disc = DISC_W'(r_s2.bb);
        end else if (w_acn) begin
            n_s3.disc = DISC_W'(r_s2.bb) + DISC_W'(w_p4);
        end else begin
            n_s3.disc = DISC_W'(r_s2.bb) - DISC_W'(w_p4);
        end

        priority if (r_s2.s.a0 && r_s2.s.b0) begin
            n_s3.kind = KIND_NONE;
        end else if (r_s2.s.a0) begin
            n_s3.kind = KIND_LINEAR;
        end else if (r_s2.s.b0) begin
            priority if (r_s2.s.c0) begin
                n_s3.kind = KIND_ZERO;
            end else if (r_s2.s.c_neg == r_s2.s.a_neg) begin
                n_s3.kind = KIND_NO_REAL;
            end else begin
                n_s3.kind = KIND_TWO;
                n_s3.sqb0 = 1'b1;
            end
        end else if (!r_s2.s.c0 && !w_acn && w_eq) begin
            n_s3.kind = KIND_DOUBLE;
        end else if (!r_s2.s.c0 && !w_acn && w_lt) begin
            n_s3.kind = KIND_NO_REAL;
        end else begin
            n_s3.kind = KIND_TWO;
        end
    end

    // ---------------- |c|*2^32 / |a| for the b = 0 case ----------------
    logic [DIV_NUM_W-1:0] w_pquo;
    t_side                r_dl1 [DIV_STAGES];

    qrs_div u_pdiv (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num ({r_s3.cm, COEF_W'(0)}),
        .i_den ({1'b0, r_s3.am}),
        .o_quo (w_pquo)
    );

    // ---------------- square root ----------------
    logic [SQ_RAD_W-1:0]  w_rad;
    logic [SQ_ROOT_W-1:0] w_sroot;
    t_side                r_dl2 [SQ_STEPS];

    assign w_rad = r_dl1[DIV_STAGES-1].sqb0
                 ? SQ_RAD_W'(w_pquo)
                 : SQ_RAD_W'(r_dl1[DIV_STAGES-1].disc);

    qrs_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (w_rad),
        .o_root (w_sroot)
    );

    // ---------------- S4: root numerators ----------------
    t_s4         r_s4, n_s4;
    t_side       w_sd4;
    logic [35:0] w_s36, w_b36, w_np, w_nn, w_npm, w_nnm;

    always_comb begin
        w_sd4 = r_dl2[SQ_STEPS-1];
        w_s36 = 36'(w_sroot);
        w_b36 = {{4{w_sd4.b[COEF_W-1]}}, w_sd4.b};
        w_np  = w_s36 - w_b36;
        w_nn  = 36'd0 - w_b36 - w_s36;
        w_npm = w_np[35] ? 36'd0 - w_np : w_np;
        w_nnm = w_nn[35] ? 36'd0 - w_nn : w_nn;

        n_s4      = '0;
        n_s4.sd   = w_sd4;
        n_s4.den  = DIV_DEN_W'(1);
        n_s4.sd.neg1 = 1'b0;
        n_s4.sd.neg2 = 1'b0;

        unique case (w_sd4.kind)
            KIND_LINEAR: begin
                n_s4.num1    = {16'd0, w_sd4.cm, 16'd0};
                n_s4.den     = {1'b0, w_sd4.bm};
                n_s4.sd.neg1 = w_sd4.c_pos != w_sd4.b_neg;
            end
            KIND_DOUBLE: begin
                n_s4.num1    = {16'd0, w_sd4.bm, 16'd0};
                n_s4.den     = {w_sd4.am, 1'b0};
                n_s4.sd.neg1 = !w_sd4.b_neg != w_sd4.a_neg;
            end
            KIND_TWO: begin
                if (w_sd4.sqb0) begin
                    // roots are +s and -s: divide s*2^16 by 2^16
                    n_s4.num1    = {14'd0, w_sroot, 16'd0};
                    n_s4.num2    = {14'd0, w_sroot, 16'd0};
                    n_s4.den     = DIV_DEN_W'(65536);
                    n_s4.sd.neg2 = 1'b1;
                end else begin
                    n_s4.num1    = {12'd0, w_npm, 16'd0};
                    n_s4.num2    = {12'd0, w_nnm, 16'd0};
                    n_s4.den     = {w_sd4.am, 1'b0};
                    n_s4.sd.neg1 = w_np[35] != w_sd4.a_neg;
                    n_s4.sd.neg2 = w_nn[35] != w_sd4.a_neg;
                end
            end
            default: begin
                n_s4.num1 = '0;
                n_s4.num2 = '0;
            end
        endcase
    end

    // ---------------- root dividers ----------------
    logic [DIV_NUM_W-1:0] w_quo [2];
    t_side                r_dl3 [DIV_STAGES];

    qrs_div u_rdiv1 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_s4.num1),
        .i_den (r_s4.den),
        .o_quo (w_quo[0])
    );

    qrs_div u_rdiv2 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_s4.num2),
        .i_den (r_s4.den),
        .o_quo (w_quo[1])
    );

    // ---------------- S5: sign and clamp ----------------
    t_tail r_tl [TAIL_N];
    t_tail n_s5;
    t_side w_sd5;
    logic [1:0] w_ng, w_sat;

    always_comb begin
        w_sd5 = r_dl3[DIV_STAGES-1];
        w_ng  = {w_sd5.neg2, w_sd5.neg1};

        n_s5       = '0;
        n_s5.vld   = w_sd5.vld;
        n_s5.kind  = w_sd5.kind;
        n_s5.a_neg = w_sd5.a_neg;
        n_s5.b_neg = w_sd5.b_neg;
        n_s5.c_neg = w_sd5.c_neg;
        n_s5.am    = w_sd5.am;
        n_s5.bm    = w_sd5.bm;
        n_s5.cm    = w_sd5.cm;
        n_s5.rep[0] = (w_sd5.kind == KIND_LINEAR) || (w_sd5.kind == KIND_DOUBLE)
                   || (w_sd5.kind == KIND_TWO);
        n_s5.rep[1] = (w_sd5.kind == KIND_TWO);

        for (int l = 0; l < 2; l++) begin
            if (!w_ng[l]) begin
                w_sat[l]    = |w_quo[l][DIV_NUM_W-1:COEF_W-1];
                n_s5.xm[l]  = w_sat[l] ? 32'h7FFF_FFFF : w_quo[l][COEF_W-1:0];
                n_s5.x[l]   = n_s5.xm[l];
            end else begin
                w_sat[l]    = (|w_quo[l][DIV_NUM_W-1:COEF_W])
                           || (w_quo[l][COEF_W-1] && (|w_quo[l][COEF_W-2:0]));
                n_s5.xm[l]  = w_sat[l] ? 32'h8000_0000 : w_quo[l][COEF_W-1:0];
                n_s5.x[l]   = COEF_W'(0) - n_s5.xm[l];
            end
            n_s5.xneg[l] = n_s5.x[l][COEF_W-1];
        end
        n_s5.sat = |w_sat;
    end

    // ---------------- S6..S11: residual a*x^2 + b*x*2^16 + c*2^32 ----------------
    logic [2*COEF_W-1:0] r_x2  [2];
    logic [2*COEF_W-1:0] r_bx6 [2];
    logic [2*COEF_W-1:0] r_plo [2];
    logic [2*COEF_W-1:0] r_phi [2];
    logic [2*COEF_W-1:0] r_bx7 [2];
    logic [RES_W-1:0]    r_at  [2];
    logic [2*COEF_W-1:0] r_bx8 [2];
    logic [RES_W-1:0]    r_t1  [2];
    logic [RES_W-1:0]    r_t2  [2];
    logic [RES_W-1:0]    r_t3  [2];
    logic [RES_W-1:0]    r_acc [2];
    logic [1:0]          r_poor;

    logic signed [RES_W-1:0] w_lim_pos, w_lim_neg;
    assign w_lim_pos = $signed({{(RES_W-LIMIT_W-32){1'b0}}, r_limit, 32'd0});
    assign w_lim_neg = -w_lim_pos;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < 2; l++) begin
                // S6
                r_x2[l]  <= 64'(r_tl[0].xm[l]) * 64'(r_tl[0].xm[l]);
                r_bx6[l] <= 64'(r_tl[0].bm) * 64'(r_tl[0].xm[l]);
                // S7
                r_plo[l] <= 64'(r_tl[1].am) * 64'(r_x2[l][31:0]);
                r_phi[l] <= 64'(r_tl[1].am) * 64'(r_x2[l][63:32]);
                r_bx7[l] <= r_bx6[l];
                // S8
                r_at[l]  <= {r_phi[l], 32'd0} + RES_W'(r_plo[l]);
                r_bx8[l] <= r_bx7[l];
                // S9: apply signs
                r_t1[l]  <= r_tl[3].a_neg ? RES_W'(0) - r_at[l] : r_at[l];
                r_t2[l]  <= (r_tl[3].b_neg ^ r_tl[3].xneg[l])
                          ? RES_W'(0) - {16'd0, r_bx8[l], 16'd0}
                          : {16'd0, r_bx8[l], 16'd0};
                r_t3[l]  <= r_tl[3].c_neg
                          ? RES_W'(0) - {32'd0, r_tl[3].cm, 32'd0}
                          : {32'd0, r_tl[3].cm, 32'd0};
                // S10
                r_acc[l] <= r_t1[l] + r_t2[l] + r_t3[l];
                // S11
                r_poor[l] <= r_check_en && r_tl[5].rep[l]
                          && (($signed(r_acc[l]) > w_lim_pos)
                           || ($signed(r_acc[l]) < w_lim_neg));
            end
        end
    end

    // ---------------- pipeline registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.vld   <= 1'b0;
            r_s2.s.vld <= 1'b0;
            r_s3.vld   <= 1'b0;
            r_s4.sd.vld <= 1'b0;
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_dl1[k].vld <= 1'b0;
                r_dl3[k].vld <= 1'b0;
            end
            for (int k = 0; k < SQ_STEPS; k++) begin
                r_dl2[k].vld <= 1'b0;
            end
            for (int k = 0; k < TAIL_N; k++) begin
                r_tl[k].vld <= 1'b0;
            end
        end else if (w_en) begin
            r_s1    <= n_s1;
            r_s2.s  <= r_s1;
            r_s2.bb <= 64'(r_s1.bm) * 64'(r_s1.bm);
            r_s2.ac <= 64'(r_s1.am) * 64'(r_s1.cm);
            r_s3    <= n_s3;
            r_dl1[0] <= r_s3;
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_dl1[k] <= r_dl1[k-1];
            end
            r_dl2[0] <= r_dl1[DIV_STAGES-1];
            for (int k = 1; k < SQ_STEPS; k++) begin
                r_dl2[k] <= r_dl2[k-1];
            end
            r_s4     <= n_s4;
            r_dl3[0] <= r_s4.sd;
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_dl3[k] <= r_dl3[k-1];
            end
            r_tl[0] <= n_s5;
            for (int k = 1; k < TAIL_N; k++) begin
                r_tl[k] <= r_tl[k-1];
            end
        end
    end

    // ---------------- output buffer, two entries ----------------
    t_out r_ob [2];
    t_out n_out;

    assign w_push = w_en && r_tl[TAIL_N-1].vld;
    assign w_pop  = o_m_tvalid && i_m_tready;

    always_comb begin
        n_out      = '0;
        n_out.kind = r_tl[TAIL_N-1].kind;
        n_out.r1   = r_tl[TAIL_N-1].x[0];
        n_out.r2   = r_tl[TAIL_N-1].x[1];
        n_out.p1   = r_poor[0];
        n_out.p2   = r_poor[1];
        n_out.sat  = r_tl[TAIL_N-1].sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_ob[r_wp] <= n_out;
        end
    end

    assign o_m_tvalid = (r_cnt != 2'd0);
    assign o_m_tuser  = r_ob[r_rp].kind;
    assign o_m_tdata  = {5'd0, r_ob[r_rp].sat, r_ob[r_rp].p2, r_ob[r_rp].p1,
                         r_ob[r_rp].r2, r_ob[r_rp].r1};

endmodule

### rtl/core/qrs_checker.sv
// Port-level checks for the quadratic root solver, bound to the top level.
module qrs_checker import qrs_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_s_tready,
    input logic [OUT_DATA_W-1:0] o_m_tdata,
    input logic [OUT_USER_W-1:0] o_m_tuser,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready
);

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tuser))
        else $error("stalled result changed");

    // input backpressure only while a result waits
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("input stalled with empty output");

    // kinds without roots carry all-zero payload
    a_no_root_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == KIND_NONE || o_m_tuser == KIND_ZERO
                       || o_m_tuser == KIND_NO_REAL)
        |-> o_m_tdata == '0)
        else $error("rootless result with nonzero payload");

    // second root and its flag only for two roots
    a_second_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != KIND_TWO
        |-> o_m_tdata[63:32] == '0 && !o_m_tdata[65])
        else $error("second root reported for single-root kind");

endmodule

bind quadratic_root_solver_core qrs_checker u_qrs_checker (.*);
